@@ rtl/assert_macros.svh @@
// assertion macros, used by the tlec_ctrl module
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLEC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tlec check failed");
`define TLEC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("tlec check failed");
`else
`define TLEC_ASSERT(lbl, prop)
`define TLEC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/tlec_pkg.sv @@
// shared types, constants and helpers of the two-level exclusive cache tags
// no dependencies
package tlec_pkg;

    localparam int ADDR_W   = 32;
    localparam int OFF_W    = 5;
    localparam int L1_WAYS  = 4;
    localparam int L1_WAY_W = 2;
    localparam int L1_SETS  = 64;
    localparam int L1_SET_W = 6;
    localparam int L1_TAG_W = ADDR_W - OFF_W - L1_SET_W;
    localparam int L2_WAYS  = 8;
    localparam int L2_WAY_W = 3;
    localparam int L2_SETS  = 256;
    localparam int L2_SET_W = 8;
    localparam int L2_TAG_W = ADDR_W - OFF_W - L2_SET_W;
    // extra l2 set bits taken from the low end of an l1 tag
    localparam int XSET_W   = L2_SET_W - L1_SET_W;

    typedef enum logic [2:0] {
        RES_NONE    = 3'd0,
        RES_RD_HIT  = 3'd1,
        RES_RD_MISS = 3'd2,
        RES_WR_HIT  = 3'd3,
        RES_WR_MISS = 3'd4
    } res_t;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [L1_WAYS-1:0]               valid;
        logic [L1_WAYS-1:0]               dirty;
        logic [L1_WAYS-1:0][L1_TAG_W-1:0] tag;
        logic [L1_WAY_W-1:0]              ptr;
    } l1_row_t;

    typedef struct packed {
        logic [L2_WAYS-1:0]               valid;
        logic [L2_WAYS-1:0]               dirty;
        logic [L2_WAYS-1:0][L2_TAG_W-1:0] tag;
        logic [L2_WAY_W-1:0]              ptr;
    } l2_row_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic ev_rd;
        logic ev_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_evict;
    } status_t;

    // lowest invalid way of an l1 set
    function automatic logic [L1_WAY_W-1:0] l1_free(input logic [L1_WAYS-1:0] v);
        logic [L1_WAY_W-1:0] w;
        w = '0;
        for (int i = L1_WAYS - 1; i >= 0; i--) begin
            if (!v[i]) w = L1_WAY_W'(i);
        end
        return w;
    endfunction

    // lowest invalid way of an l2 set
    function automatic logic [L2_WAY_W-1:0] l2_free(input logic [L2_WAYS-1:0] v);
        logic [L2_WAY_W-1:0] w;
        w = '0;
        for (int i = L2_WAYS - 1; i >= 0; i--) begin
            if (!v[i]) w = L2_WAY_W'(i);
        end
        return w;
    endfunction

endpackage

@@ rtl/tlec_ctrl.sv @@
// controller state machine: sequences lookup, victim move and result hand-off
// depends on tlec_pkg and assert_macros.svh
`include "assert_macros.svh"
module tlec_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tlec_pkg::status_t status,
    output tlec_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EV_RD,
        S_EV_WR,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // commands decoded from state
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.lookup   = (state_reg == S_LOOK);
        cmd.ev_rd    = (state_reg == S_EV_RD);
        cmd.ev_wr    = (state_reg == S_EV_WR);
        cmd.load_out = (state_reg == S_DONE) && out_free;
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_LOOK;
            S_LOOK:  state_next = status.need_evict ? S_EV_RD : S_DONE;
            S_EV_RD: state_next = S_EV_WR;
            S_EV_WR: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TLEC_ASSERT(a_accept_to_look, (in_valid && in_ready) |=> (state_reg == S_LOOK))
    `TLEC_ASSERT(a_evrd_after_look, (state_reg == S_EV_RD) |-> ($past(state_reg) == S_LOOK))
    `TLEC_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_valid_reg || out_ready))

endmodule

@@ rtl/tlec_datapath.sv @@
// datapath: l1 and l2 tag row memories, hit detection, fill and victim placement
// depends on tlec_pkg
module tlec_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlec_pkg::cmd_t        cmd,
    output tlec_pkg::status_t     status,
    input  logic                  op,
    input  logic [31:0]           access_address,
    output logic [2:0]            l1_result,
    output logic [2:0]            l2_result,
    output logic                  memory_write
);

    localparam int OFF_W    = tlec_pkg::OFF_W;
    localparam int L1_SET_W = tlec_pkg::L1_SET_W;
    localparam int L2_SET_W = tlec_pkg::L2_SET_W;
    localparam int L1_TAG_W = tlec_pkg::L1_TAG_W;
    localparam int L2_TAG_W = tlec_pkg::L2_TAG_W;
    localparam int XSET_W   = tlec_pkg::XSET_W;

    // row memories and per-row written flags
    tlec_pkg::l1_row_t l1_mem [tlec_pkg::L1_SETS];
    tlec_pkg::l2_row_t l2_mem [tlec_pkg::L2_SETS];
    logic [tlec_pkg::L1_SETS-1:0] l1_ok_reg;
    logic [tlec_pkg::L2_SETS-1:0] l2_ok_reg;
    tlec_pkg::l1_row_t l1_rd_reg;
    tlec_pkg::l2_row_t l2_rd_reg;

    logic                 op_reg;
    logic [31:0]          addr_reg;
    logic [L1_TAG_W-1:0]  vic_tag_reg;
    logic                 vic_dirty_reg;
    tlec_pkg::res_t       r1_reg, r2_reg;
    logic                 mem_reg;
    tlec_pkg::res_t       r1_out_reg, r2_out_reg;
    logic                 mem_out_reg;

    logic [L1_SET_W-1:0]  set1, in_set1;
    logic [L2_SET_W-1:0]  set2, in_set2, vic_set2, l2_raddr, l2_waddr, l2_cur_set;
    logic [L1_TAG_W-1:0]  tag1;
    logic [L2_TAG_W-1:0]  tag2, vic_tag2;

    tlec_pkg::l1_row_t l1_cur, l1_wdata;
    tlec_pkg::l2_row_t l2_cur, l2_wdata;
    logic              l1_we, l2_we;
    logic              hit1, hit2, full1, full2;
    logic [tlec_pkg::L1_WAY_W-1:0] hit1_way, fill1_way;
    logic [tlec_pkg::L2_WAY_W-1:0] hit2_way, fill2_way;
    logic              new_dirty;
    tlec_pkg::res_t    lk_r1, lk_r2;
    logic              lk_mem, ev_mem;

    // address split
    assign in_set1  = access_address[OFF_W +: L1_SET_W];
    assign in_set2  = access_address[OFF_W +: L2_SET_W];
    assign set1     = addr_reg[OFF_W +: L1_SET_W];
    assign set2     = addr_reg[OFF_W +: L2_SET_W];
    assign tag1     = addr_reg[31 -: L1_TAG_W];
    assign tag2     = addr_reg[31 -: L2_TAG_W];
    assign vic_set2 = {vic_tag_reg[XSET_W-1:0], set1};
    assign vic_tag2 = vic_tag_reg[L1_TAG_W-1:XSET_W];

    assign l2_raddr   = cmd.ev_rd ? vic_set2 : in_set2;
    assign l2_cur_set = cmd.ev_wr ? vic_set2 : set2;
    assign l2_waddr   = l2_cur_set;

    // current rows, never-written rows read as empty
    assign l1_cur = l1_ok_reg[set1] ? l1_rd_reg : '0;
    assign l2_cur = l2_ok_reg[l2_cur_set] ? l2_rd_reg : '0;

    // tag compare over the ways
    always_comb
    begin
        hit1     = 1'b0;
        hit1_way = '0;
        for (int w = 0; w < tlec_pkg::L1_WAYS; w++)
        begin
            if (l1_cur.valid[w] && l1_cur.tag[w] == tag1)
            begin
                hit1     = 1'b1;
                hit1_way = tlec_pkg::L1_WAY_W'(w);
            end
        end
        hit2     = 1'b0;
        hit2_way = '0;
        for (int w = 0; w < tlec_pkg::L2_WAYS; w++)
        begin
            if (l2_cur.valid[w] && l2_cur.tag[w] == tag2)
            begin
                hit2     = 1'b1;
                hit2_way = tlec_pkg::L2_WAY_W'(w);
            end
        end
    end

    assign full1     = &l1_cur.valid;
    assign full2     = &l2_cur.valid;
    assign fill1_way = full1 ? l1_cur.ptr : tlec_pkg::l1_free(l1_cur.valid);
    assign fill2_way = full2 ? l2_cur.ptr : tlec_pkg::l2_free(l2_cur.valid);
    assign new_dirty = hit2 && l2_cur.dirty[hit2_way];
    assign ev_mem    = full2 && l2_cur.dirty[l2_cur.ptr];

    assign status.need_evict = (op_reg == tlec_pkg::OP_READ) && !hit1 && full1;

    // lookup step and victim placement
    always_comb
    begin
        l1_wdata = l1_cur;
        l2_wdata = l2_cur;
        l1_we    = 1'b0;
        l2_we    = 1'b0;
        lk_r1    = tlec_pkg::RES_NONE;
        lk_r2    = tlec_pkg::RES_NONE;
        lk_mem   = 1'b0;
        if (cmd.ev_wr)
        begin
            l2_wdata.valid[fill2_way] = 1'b1;
            l2_wdata.dirty[fill2_way] = vic_dirty_reg;
            l2_wdata.tag[fill2_way]   = vic_tag2;
            if (full2) l2_wdata.ptr = l2_cur.ptr + 1'b1;
            l2_we = 1'b1;
        end
        else if (cmd.lookup)
        begin
            if (op_reg == tlec_pkg::OP_READ)
            begin
                if (hit1)
                begin
                    lk_r1 = tlec_pkg::RES_RD_HIT;
                end
                else
                begin
                    lk_r1 = tlec_pkg::RES_RD_MISS;
                    lk_r2 = hit2 ? tlec_pkg::RES_RD_HIT : tlec_pkg::RES_RD_MISS;
                    // block leaves l2 on a hit
                    if (hit2)
                    begin
                        l2_wdata.valid[hit2_way] = 1'b0;
                        l2_we = 1'b1;
                    end
                    // fill l1, over the round-robin victim when full
                    l1_wdata.valid[fill1_way] = 1'b1;
                    l1_wdata.dirty[fill1_way] = new_dirty;
                    l1_wdata.tag[fill1_way]   = tag1;
                    if (full1) l1_wdata.ptr = l1_cur.ptr + 1'b1;
                    l1_we = 1'b1;
                end
            end
            else
            begin
                if (hit1)
                begin
                    lk_r1 = tlec_pkg::RES_WR_HIT;
                    l1_wdata.dirty[hit1_way] = 1'b1;
                    l1_we = 1'b1;
                end
                else
                begin
                    lk_r1 = tlec_pkg::RES_WR_MISS;
                    if (hit2)
                    begin
                        lk_r2 = tlec_pkg::RES_WR_HIT;
                        l2_wdata.dirty[hit2_way] = 1'b1;
                        l2_we = 1'b1;
                    end
                    else
                    begin
                        lk_r2  = tlec_pkg::RES_WR_MISS;
                        lk_mem = 1'b1;
                    end
                end
            end
        end
    end

    // l1 row memory
    always_ff @(posedge clk)
    begin
        if (l1_we) l1_mem[set1] <= l1_wdata;
        if (cmd.capture) l1_rd_reg <= l1_mem[in_set1];
    end

    // l2 row memory
    always_ff @(posedge clk)
    begin
        if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
        if (cmd.capture || cmd.ev_rd) l2_rd_reg <= l2_mem[l2_raddr];
    end

    // row written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_ok_reg <= '0;
            l2_ok_reg <= '0;
        end
        else
        begin
            if (l1_we) l1_ok_reg[set1] <= 1'b1;
            if (l2_we) l2_ok_reg[l2_waddr] <= 1'b1;
        end
    end

    // request, victim and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            addr_reg <= access_address;
        end
        if (cmd.lookup)
        begin
            vic_tag_reg   <= l1_cur.tag[l1_cur.ptr];
            vic_dirty_reg <= l1_cur.dirty[l1_cur.ptr];
            r1_reg        <= lk_r1;
            r2_reg        <= lk_r2;
            mem_reg       <= lk_mem;
        end
        if (cmd.ev_wr) mem_reg <= ev_mem;
        if (cmd.load_out)
        begin
            r1_out_reg  <= r1_reg;
            r2_out_reg  <= r2_reg;
            mem_out_reg <= mem_reg;
        end
    end

    assign l1_result    = r1_out_reg;
    assign l2_result    = r2_out_reg;
    assign memory_write = mem_out_reg;

endmodule

@@ rtl/two_level_exclusive_cache_tags.sv @@
// top level: tag, valid and dirty tracking of an exclusive two-level cache
// each request is captured, looked up, then its result loaded; an l1 victim move to l2
// adds an l2 read and write step; a new request waits for the last result to be loaded
// reset clears all valid, dirty and victim pointers at once through per-row flags
// depends on tlec_pkg, tlec_ctrl and tlec_datapath
module two_level_exclusive_cache_tags
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] access_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  l1_result,
    output logic [2:0]  l2_result,
    output logic        memory_write
);

    tlec_pkg::cmd_t    cmd;
    tlec_pkg::status_t status;

    // sequencing
    tlec_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // tag arrays and result logic
    tlec_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .op             (op),
        .access_address (access_address),
        .l1_result      (l1_result),
        .l2_result      (l2_result),
        .memory_write   (memory_write)
    );

endmodule
